// File: hdl/nps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants shared by the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

   // Set capacity; the index field is 12 bits, so the capacity tops out there.
   localparam int MAX_POINTS = 4096;
   localparam int INDEX_W    = 12;
   localparam int POS_CAP    = (MAX_POINTS < (1 << INDEX_W)) ? MAX_POINTS : (1 << INDEX_W);
   localparam int CNT_W      = $clog2(POS_CAP + 1);

   localparam int COORD_W = 16;
   localparam int LIMIT_W = 16;
   localparam int ADIFF_W = COORD_W;           // |a - b| of two 16 bit values fits 16 bits
   localparam int SQ_W    = 2 * ADIFF_W;
   localparam int DIST_W  = SQ_W + 2;          // sum of three squares
   localparam int LSQ_W   = 2 * LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_X = 2'd0,
      CSR_REF_Y = 2'd1,
      CSR_REF_Z = 2'd2,
      CSR_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] near_x;
      logic signed [COORD_W-1:0] near_y;
      logic signed [COORD_W-1:0] near_z;
      logic [INDEX_W-1:0]        near_index;
      logic                      found;
      logic                      overflow;
   } rsp_type;

   // One beat after the squaring stage
   typedef struct packed {
      logic [SQ_W-1:0]           sq_x;
      logic [SQ_W-1:0]           sq_y;
      logic [SQ_W-1:0]           sq_z;
      logic [LSQ_W-1:0]          lim_sq;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
   } sq_type;

endpackage : nps_pkg
`default_nettype wire

// File: hdl/nearest_point_search.sv
`default_nettype none
// A point beat is registered in in_ff, then in sq_ff for the compare stage;
//   a last-point beat holds there until rsp_ff is free, then shows on rsp_valid.
// Throughput: one point per cycle unless held, set by the best-distance loop.
// Reset (synchronous): clears the set state and pipeline, reference to 0, limit to 1024.
// ----------------------------------------------------------------------------
// nearest_point_search
// Streams 3D points, tracks the one nearest the reference under the limit
// and returns it, its index and the found/overflow flags on the last point.
// ----------------------------------------------------------------------------
module nearest_point_search
   import nps_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,

   input  wire logic                 csr_we,
   input  wire csr_index_type        csr_index,
   input  wire logic [LIMIT_W-1:0]   csr_wdata
);

   function automatic logic [ADIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      abs_diff = d[COORD_W] ? ADIFF_W'(-d) : d[ADIFF_W-1:0];
   endfunction

   // configuration
   logic signed [COORD_W-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic [LIMIT_W-1:0]        limit_ff;

   // pipeline
   logic    in_valid_ff, sq_valid_ff, rsp_valid_ff;
   req_type in_ff;
   sq_type  sq_ff, sq_in;
   rsp_type rsp_ff, rsp_in;

   // set state
   logic [DIST_W-1:0]         best_sq_ff, best_sq_in;
   logic [INDEX_W-1:0]        best_pos_ff, best_pos_in;
   logic signed [COORD_W-1:0] best_x_ff, best_y_ff, best_z_ff;
   logic signed [COORD_W-1:0] best_x_in, best_y_in, best_z_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      found_ff, found_in;
   logic                      ovf_ff, ovf_in;

   logic [ADIFF_W-1:0] ax, ay, az;
   logic [DIST_W-1:0]  dist_sq;
   logic               win;
   logic               out_free, sq_go, sq_free, in_free, emit;

   // handshake: a non-last beat in the compare stage never waits on the output
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sq_go     = sq_valid_ff && (!sq_ff.last_point || out_free);
   assign sq_free   = !sq_valid_ff || sq_go;
   assign in_free   = !in_valid_ff || sq_free;
   assign req_ready = in_free;
   assign emit      = sq_go && sq_ff.last_point;

   // squaring stage
   always_comb begin
      ax = abs_diff(in_ff.point_x, ref_x_ff);
      ay = abs_diff(in_ff.point_y, ref_y_ff);
      az = abs_diff(in_ff.point_z, ref_z_ff);
      sq_in.sq_x       = SQ_W'(ax) * SQ_W'(ax);
      sq_in.sq_y       = SQ_W'(ay) * SQ_W'(ay);
      sq_in.sq_z       = SQ_W'(az) * SQ_W'(az);
      sq_in.lim_sq     = LSQ_W'(limit_ff) * LSQ_W'(limit_ff);
      sq_in.point_x    = in_ff.point_x;
      sq_in.point_y    = in_ff.point_y;
      sq_in.point_z    = in_ff.point_z;
      sq_in.last_point = in_ff.last_point;
   end

   // compare stage
   always_comb begin
      dist_sq = DIST_W'(sq_ff.sq_x) + DIST_W'(sq_ff.sq_y) + DIST_W'(sq_ff.sq_z);
      win     = (dist_sq < DIST_W'(sq_ff.lim_sq)) && (!found_ff || dist_sq < best_sq_ff);

      best_sq_in  = best_sq_ff;
      best_pos_in = best_pos_ff;
      best_x_in   = best_x_ff;
      best_y_in   = best_y_ff;
      best_z_in   = best_z_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      ovf_in      = ovf_ff;

      if (count_ff >= CNT_W'(POS_CAP)) begin
         ovf_in = 1'b1;
      end else begin
         // first point of a set is the fallback answer
         if (count_ff == '0) begin
            best_x_in   = sq_ff.point_x;
            best_y_in   = sq_ff.point_y;
            best_z_in   = sq_ff.point_z;
            best_pos_in = '0;
         end
         if (win) begin
            best_sq_in  = dist_sq;
            best_pos_in = INDEX_W'(count_ff);
            best_x_in   = sq_ff.point_x;
            best_y_in   = sq_ff.point_y;
            best_z_in   = sq_ff.point_z;
            found_in    = 1'b1;
         end
         count_in = count_ff + CNT_W'(1);
      end

      rsp_in.near_x     = best_x_in;
      rsp_in.near_y     = best_y_in;
      rsp_in.near_z     = best_z_in;
      rsp_in.near_index = best_pos_in;
      rsp_in.found      = found_in;
      rsp_in.overflow   = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff     <= '0;
         ref_y_ff     <= '0;
         ref_z_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_sq_ff   <= '0;
         best_pos_ff  <= '0;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         best_z_ff    <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REF_X: ref_x_ff <= csr_wdata;
               CSR_REF_Y: ref_y_ff <= csr_wdata;
               CSR_REF_Z: ref_z_ff <= csr_wdata;
               CSR_LIMIT: limit_ff <= csr_wdata;
               default:   ;
            endcase
         end

         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (sq_free) begin
            sq_valid_ff <= in_valid_ff;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (emit) begin
            // set done: back to a clean set
            best_sq_ff  <= '0;
            best_pos_ff <= '0;
            best_x_ff   <= '0;
            best_y_ff   <= '0;
            best_z_ff   <= '0;
            count_ff    <= '0;
            found_ff    <= 1'b0;
            ovf_ff      <= 1'b0;
         end else if (sq_go) begin
            best_sq_ff  <= best_sq_in;
            best_pos_ff <= best_pos_in;
            best_x_ff   <= best_x_in;
            best_y_ff   <= best_y_in;
            best_z_ff   <= best_z_in;
            count_ff    <= count_in;
            found_ff    <= found_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_ff <= req_data;
      end
      if (sq_free && in_valid_ff) begin
         sq_ff <= sq_in;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POS_CAP))
      else $error("point counter past capacity");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> count_ff == CNT_W'(POS_CAP))
      else $error("overflow set without saturated counter");

   a_found_cnt: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> count_ff != '0)
      else $error("winner recorded in an empty set");

   a_notfound_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.near_index == '0)
      else $error("index nonzero with no point found");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sq_valid_ff && sq_ff.last_point))
      else $error("result raised without a last-point beat");

endmodule : nearest_point_search
`default_nettype wire

// File: bench/tb_nearest_point_search.sv
// ----------------------------------------------------------------------------
// tb_nearest_point_search
// Streams sets of 3D points into the nearest point search block and checks
// every result beat against a running in-bench search over the same points,
// across reference and limit settings, set sizes up to and past capacity,
// and random idling on the point and result channels.
// ----------------------------------------------------------------------------
module tb_nearest_point_search
   import nps_pkg::*;
;

   localparam int IDLE_PCT      = 13;
   localparam int SETTLE_CYCLES = 6;
   localparam int STALL_LIMIT   = 2000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   csr_index_type      csr_index = CSR_REF_X;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   bit      quiet        = 1'b0;
   int      mismatches   = 0;
   int      stall_cycles = 0;
   rsp_type pending_nearest[$];

   // Search state mirrored in the bench
   logic signed [COORD_W-1:0] ref_px     = '0;
   logic signed [COORD_W-1:0] ref_py     = '0;
   logic signed [COORD_W-1:0] ref_pz     = '0;
   logic [LIMIT_W-1:0]        dist_limit = LIMIT_RESET;
   longint                    best_dist2 = 0;
   int                        best_at    = 0;
   req_type                   best_beat  = '0;
   int                        seen       = 0;
   bit                        have_winner = 1'b0;
   bit                        spilled     = 1'b0;

   nearest_point_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void clear_set();
      best_dist2  = 0;
      best_at     = 0;
      best_beat   = '0;
      seen        = 0;
      have_winner = 1'b0;
      spilled     = 1'b0;
   endfunction

   function automatic longint sq_diff(input logic signed [COORD_W-1:0] a,
                                      input logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   // Folds one point into the set; returns 1 with the result on the last point.
   function automatic bit advance_search(input req_type beat, output rsp_type near);
      longint d2;
      longint lim2;
      near = '0;
      if (seen >= POS_CAP) begin
         spilled = 1'b1;
      end else begin
         d2   = sq_diff(beat.point_x, ref_px) + sq_diff(beat.point_y, ref_py) +
                sq_diff(beat.point_z, ref_pz);
         lim2 = longint'(dist_limit) * longint'(dist_limit);
         if (seen == 0) begin
            best_beat = beat;
            best_at   = 0;
         end
         if (d2 < lim2 && (!have_winner || d2 < best_dist2)) begin
            best_dist2  = d2;
            best_at     = seen;
            best_beat   = beat;
            have_winner = 1'b1;
         end
         seen++;
      end
      if (!beat.last_point)
         return 1'b0;
      near.near_x     = best_beat.point_x;
      near.near_y     = best_beat.point_y;
      near.near_z     = best_beat.point_z;
      near.near_index = INDEX_W'(best_at);
      near.found      = have_winner;
      near.overflow   = spilled;
      clear_set();
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Called at a rising edge; returns at the edge where the beat is taken.
   task automatic send_point(input logic signed [COORD_W-1:0] x, y, z,
                             input logic last);
      req_type beat;
      rsp_type near;
      beat.point_x    = x;
      beat.point_y    = y;
      beat.point_z    = z;
      beat.last_point = last;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (advance_search(beat, near))
         pending_nearest.push_back(near);
   endtask

   // Holds points back until all results are in and the pipeline has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_nearest.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [LIMIT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_registers(input logic signed [COORD_W-1:0] x, y, z,
                                 input logic [LIMIT_W-1:0] limit);
      put_reg(CSR_REF_X, x);
      put_reg(CSR_REF_Y, y);
      put_reg(CSR_REF_Z, z);
      put_reg(CSR_LIMIT, limit);
      csr_we <= 1'b0;
      @(posedge clock);
      ref_px     = x;
      ref_py     = y;
      ref_pz     = z;
      dist_limit = limit;
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord(
         input logic signed [COORD_W-1:0] center, input int span);
      int roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return COORD_W'(int'(center) + int'($urandom_range(2 * span)) - span);
      else if (roll < 85)
         return COORD_W'($urandom);
      else if (roll < 92)
         return 16'sh8000;
      else if (roll < 97)
         return 16'sh7fff;
      return center;
   endfunction

   // Runs with the reset register values: limit 1024 around the origin.
   task automatic test_default_limit();
      send_point(1024, 0, 0, 1'b0);     // exactly on the limit, not taken
      send_point(2000, 5, 5, 1'b0);
      send_point(0, 1023, 0, 1'b1);
      send_point(-1024, 0, 0, 1'b1);    // nothing under the limit
   endtask

   task automatic test_equal_distances();
      send_point(5, 0, 0, 1'b0);
      send_point(0, -5, 0, 1'b0);
      send_point(0, 0, 5, 1'b1);
      send_point(9, 9, 9, 1'b0);
      send_point(3, 4, 0, 1'b0);
      send_point(0, 0, 5, 1'b0);
      send_point(0, 0, -5, 1'b0);
      send_point(1, 1, 1, 1'b1);
   endtask

   task automatic test_extreme_settings();
      drain();
      load_registers(16'sh8000, 16'sh8000, 16'sh8000, 16'hffff);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);   // largest distance
      send_point(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);   // equals the limit
      send_point(16'sh8000, 16'sh8000, 16'sh8001, 1'b1);
      drain();
      load_registers(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b1);   // zero limit admits nothing
      drain();
      load_registers(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff);
      send_point(16'sh8001, 16'sh7fff, 16'sh7fff, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
   endtask

   task automatic test_limit_change_mid_set();
      drain();
      load_registers(0, 0, 0, 16'd100);
      send_point(50, 0, 0, 1'b0);
      send_point(60, 0, 0, 1'b0);
      drain();
      load_registers(0, 0, 0, 16'd5);
      send_point(30, 0, 0, 1'b0);      // beats the best but not the new limit
      send_point(0, 4, 0, 1'b0);
      send_point(0, 0, -3, 1'b1);
   endtask

   // A full set, then one past capacity where later points must be ignored.
   task automatic test_capacity();
      drain();
      load_registers(0, 0, 0, LIMIT_RESET);
      for (int i = 0; i < POS_CAP; i++)
         send_point(COORD_W'((i == POS_CAP - 1) ? 0 : 20000), 0, 9, i == POS_CAP - 1);
      for (int i = 0; i < POS_CAP + 4; i++) begin
         if (i == POS_CAP - 1)
            send_point(7, 0, 0, 1'b0);
         else if (i == POS_CAP + 1)
            send_point(0, 0, 0, 1'b0);
         else
            send_point(-20000, 3, 3, i == POS_CAP + 3);
      end
   endtask

   task automatic test_random_sets(input int total);
      logic signed [COORD_W-1:0] cx, cy, cz;
      logic [LIMIT_W-1:0]        lim;
      int                        sent;
      int                        span;
      int                        size;
      bit                        paused;
      for (int phase = 0; phase < 6; phase++) begin
         cx = COORD_W'($urandom);
         cy = COORD_W'($urandom);
         cz = COORD_W'($urandom);
         lim = $urandom_range(1) ? LIMIT_W'($urandom_range(4000)) : LIMIT_W'($urandom);
         case (phase)
            0: begin
               cx  = 0;
               cy  = 0;
               cz  = 0;
               lim = LIMIT_RESET;
            end
            1: begin
               cx  = 16'sh8000;
               cy  = 16'sh8000;
               cz  = 16'sh8000;
               lim = 16'hffff;
            end
            2: lim = 16'h0000;
            3: begin
               cx  = 16'sh7fff;
               cy  = 16'sh7fff;
               cz  = 16'sh7fff;
               lim = 16'hffff;
            end
            default: ;
         endcase
         drain();
         load_registers(cx, cy, cz, lim);
         quiet  = (phase == 0);   // one long stretch with both sides busy
         sent   = 0;
         paused = 1'b0;
         while (sent < total / 6) begin
            size = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            span = (lim == 0) ? 64 : int'(lim);
            if ($urandom_range(2) == 0)
               span = span / 2 + 1;
            for (int i = 0; i < size; i++)
               send_point(pick_coord(cx, span), pick_coord(cy, span),
                          pick_coord(cz, span), i == size - 1);
            sent += size;
            if (phase == 4 && !paused && sent >= total / 12) begin
               drain();
               paused = 1'b1;
            end
         end
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_nearest.size() == 0) begin
            $error("result beat with no point set pending");
            mismatches++;
         end else begin
            rsp_type want;
            want = pending_nearest.pop_front();
            check_field("near_x", longint'(want.near_x), longint'(rsp_data.near_x));
            check_field("near_y", longint'(want.near_y), longint'(rsp_data.near_y));
            check_field("near_z", longint'(want.near_z), longint'(rsp_data.near_z));
            check_field("near_index", longint'(want.near_index),
                        longint'(rsp_data.near_index));
            check_field("found", longint'(want.found), longint'(rsp_data.found));
            check_field("overflow", longint'(want.overflow), longint'(rsp_data.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_limit();
      test_equal_distances();
      test_extreme_settings();
      test_limit_change_mid_set();
      test_capacity();
      test_random_sets(650);
      drain();
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule : tb_nearest_point_search

// File: files.f
hdl/nps_pkg.sv
hdl/nearest_point_search.sv
bench/tb_nearest_point_search.sv
